[rtl/tsw_pkg.sv]
// Shared types, codes and default sizes for the trilinear stencil weight block.
package tsw_pkg;

   localparam int GRID_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_INDEX_W   = 3;

   localparam int AXIS_Z = 0;
   localparam int AXIS_X = 1;
   localparam int AXIS_Y = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_DEPTH,
      CSR_GRID_WIDTH,
      CSR_Z_FIRST_OK,
      CSR_Z_END_OK,
      CSR_X_FIRST_OK,
      CSR_X_END_OK,
      CSR_Y_FIRST_OK,
      CSR_Y_END_OK
   } csr_index_type;

   typedef enum logic [1:0] {
      FAULT_NONE,
      FAULT_Y,
      FAULT_X,
      FAULT_Z
   } fault_code_type;

   typedef struct packed {
      logic           fault;
      fault_code_type code;
      logic           pole;
      logic           dipole;
   } job_ctrl_type;

   typedef struct packed {
      logic           fault;
      fault_code_type code;
      logic           pole;
      logic           neg;
      logic           last;
   } corner_ctrl_type;

endpackage

[rtl/tsw_csr.sv]
// Configuration registers: grid strides and per-axis cell bounds.
module tsw_csr #(
   parameter int GRID_BITS = tsw_pkg::GRID_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [tsw_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [GRID_BITS:0]                    csr_wdata,
   output logic [GRID_BITS:0]                    grid_depth,
   output logic [GRID_BITS:0]                    grid_width,
   output logic [2:0][GRID_BITS-1:0]             first_ok,
   output logic [2:0][GRID_BITS:0]               end_ok
);
   import tsw_pkg::*;

   localparam int CELL_W = GRID_BITS + 1;

   logic [CELL_W-1:0]         depth_ff, depth_in;
   logic [CELL_W-1:0]         width_ff, width_in;
   logic [2:0][GRID_BITS-1:0] first_ff, first_in;
   logic [2:0][CELL_W-1:0]    end_ff, end_in;

   always_comb begin
      depth_in = depth_ff;
      width_in = width_ff;
      first_in = first_ff;
      end_in   = end_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_DEPTH: depth_in = csr_wdata;
            CSR_GRID_WIDTH: width_in = csr_wdata;
            CSR_Z_FIRST_OK: first_in[AXIS_Z] = csr_wdata[GRID_BITS-1:0];
            CSR_Z_END_OK:   end_in[AXIS_Z] = csr_wdata;
            CSR_X_FIRST_OK: first_in[AXIS_X] = csr_wdata[GRID_BITS-1:0];
            CSR_X_END_OK:   end_in[AXIS_X] = csr_wdata;
            CSR_Y_FIRST_OK: first_in[AXIS_Y] = csr_wdata[GRID_BITS-1:0];
            CSR_Y_END_OK:   end_in[AXIS_Y] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= CELL_W'(2);
         width_ff <= CELL_W'(2);
         first_ff <= '0;
         end_ff   <= {3{CELL_W'(1)}};
      end else begin
         depth_ff <= depth_in;
         width_ff <= width_in;
         first_ff <= first_in;
         end_ff   <= end_in;
      end
   end

   assign grid_depth = depth_ff;
   assign grid_width = width_ff;
   assign first_ok   = first_ff;
   assign end_ok     = end_ff;

endmodule

[rtl/tsw_front.sv]
// Front end: input register, second pole position and bounds classification.
module tsw_front #(
   parameter int GRID_BITS = tsw_pkg::GRID_BITS_DEF,
   parameter int FRAC_BITS = tsw_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic [GRID_BITS+FRAC_BITS-1:0]           req_pos_z,
   input  logic [GRID_BITS+FRAC_BITS-1:0]           req_pos_x,
   input  logic [GRID_BITS+FRAC_BITS-1:0]           req_pos_y,
   input  logic                                     req_dipole_on,
   input  logic signed [GRID_BITS+FRAC_BITS-1:0]    req_shift_z,
   input  logic signed [GRID_BITS+FRAC_BITS-1:0]    req_shift_x,
   input  logic signed [GRID_BITS+FRAC_BITS-1:0]    req_shift_y,
   input  logic [2:0][GRID_BITS-1:0]                first_ok,
   input  logic [2:0][GRID_BITS:0]                  end_ok,
   output logic                                     job_push,
   input  logic                                     job_full,
   output tsw_pkg::job_ctrl_type                    job_ctrl,
   output logic [1:0][2:0][GRID_BITS:0]             job_cell,
   output logic [1:0][2:0][FRAC_BITS-1:0]           job_frac
);
   import tsw_pkg::*;

   localparam int POS_W  = GRID_BITS + FRAC_BITS;
   localparam int CELL_W = GRID_BITS + 1;
   localparam int SUM_W  = POS_W + 2;

   logic                  valid_ff, valid_in;
   logic [2:0][POS_W-1:0] pos_ff;
   logic [2:0][POS_W-1:0] shift_ff;
   logic                  dipole_ff;
   logic                  accept;

   logic [1:0][2:0][SUM_W-1:0] sum;
   logic [1:0][2:0]            bad;
   fault_code_type [1:0]       pole_code;

   assign accept   = req_push && !req_full;
   assign req_full = valid_ff && job_full;
   assign job_push = valid_ff && !job_full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (job_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff[AXIS_Z]   <= req_pos_z;
         pos_ff[AXIS_X]   <= req_pos_x;
         pos_ff[AXIS_Y]   <= req_pos_y;
         shift_ff[AXIS_Z] <= req_shift_z;
         shift_ff[AXIS_X] <= req_shift_x;
         shift_ff[AXIS_Y] <= req_shift_y;
         dipole_ff        <= req_dipole_on;
      end
   end

   always_comb begin
      logic [CELL_W:0] cell_inc;
      for (int a = 0; a < 3; a++) begin
         sum[0][a] = {2'b00, pos_ff[a]};
         sum[1][a] = {2'b00, pos_ff[a]} + {{2{shift_ff[a][POS_W-1]}}, shift_ff[a]};
      end
      for (int p = 0; p < 2; p++) begin
         for (int a = 0; a < 3; a++) begin
            job_cell[p][a] = sum[p][a][POS_W:FRAC_BITS];
            job_frac[p][a] = sum[p][a][FRAC_BITS-1:0];
            cell_inc       = {1'b0, job_cell[p][a]} + (CELL_W+1)'(1);
            bad[p][a]      = sum[p][a][SUM_W-1]
                          || (job_cell[p][a] < {1'b0, first_ok[a]})
                          || (cell_inc >= {1'b0, end_ok[a]});
         end
         if (bad[p][AXIS_Y]) begin
            pole_code[p] = FAULT_Y;
         end else if (bad[p][AXIS_X]) begin
            pole_code[p] = FAULT_X;
         end else if (bad[p][AXIS_Z]) begin
            pole_code[p] = FAULT_Z;
         end else begin
            pole_code[p] = FAULT_NONE;
         end
      end
   end

   always_comb begin
      job_ctrl.dipole = dipole_ff;
      if (pole_code[0] != FAULT_NONE) begin
         job_ctrl.fault = 1'b1;
         job_ctrl.code  = pole_code[0];
         job_ctrl.pole  = 1'b0;
      end else if (dipole_ff && pole_code[1] != FAULT_NONE) begin
         job_ctrl.fault = 1'b1;
         job_ctrl.code  = pole_code[1];
         job_ctrl.pole  = 1'b1;
      end else begin
         job_ctrl.fault = 1'b0;
         job_ctrl.code  = FAULT_NONE;
         job_ctrl.pole  = 1'b0;
      end
   end

endmodule

[rtl/tsw_job_fifo.sv]
// Two-entry queue of classified jobs between the front and back ends.
module tsw_job_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/tsw_back.sv]
// Back end: corner sequencer and the index and weight pipeline to the output.
module tsw_back #(
   parameter int GRID_BITS = tsw_pkg::GRID_BITS_DEF,
   parameter int FRAC_BITS = tsw_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_valid,
   output logic                                  job_pop,
   input  tsw_pkg::job_ctrl_type                 job_ctrl,
   input  logic [1:0][2:0][GRID_BITS:0]          job_cell,
   input  logic [1:0][2:0][FRAC_BITS-1:0]        job_frac,
   input  logic [GRID_BITS:0]                    grid_depth,
   input  logic [GRID_BITS:0]                    grid_width,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [3*GRID_BITS-1:0]                rsp_point_index,
   output logic signed [FRAC_BITS+1:0]           rsp_corner_weight,
   output logic [1:0]                            rsp_fault_code,
   output logic                                  rsp_fault_pole,
   output logic                                  rsp_last_of_run
);
   import tsw_pkg::*;

   localparam int CELL_W = GRID_BITS + 1;
   localparam int IDX_W  = 3 * GRID_BITS;
   localparam int W_W    = FRAC_BITS + 1;
   localparam int AB_W   = 2 * W_W;
   localparam int ABC_W  = 3 * W_W;

   logic [2*CELL_W-1:0] nzx_ff, nzx_in;
   logic [3:0]          k_ff, k_in;
   logic                adv;
   logic                issue;
   logic                last_corner;

   corner_ctrl_type           sel_ctrl;
   logic [2:0][W_W-1:0]       sel_w;
   logic [2:0][CELL_W-1:0]    sel_cell;

   logic                      s0_valid_ff;
   corner_ctrl_type           s0_ctrl_ff;
   logic [2:0][W_W-1:0]       s0_w_ff;
   logic [2:0][CELL_W-1:0]    s0_cell_ff;

   logic                      s1_valid_ff;
   corner_ctrl_type           s1_ctrl_ff;
   logic [AB_W-1:0]           s1_wab_ff, s1_wab_in;
   logic [W_W-1:0]            s1_wc_ff;
   logic [IDX_W-1:0]          s1_py_ff, s1_py_in;
   logic [2*CELL_W-1:0]       s1_px_ff, s1_px_in;
   logic [CELL_W-1:0]         s1_cz_ff;

   logic                      s2_valid_ff;
   corner_ctrl_type           s2_ctrl_ff;
   logic [W_W-1:0]            s2_wgt_ff, s2_wgt_in;
   logic [IDX_W-1:0]          s2_idx_ff, s2_idx_in;

   logic                      s3_valid_ff;
   corner_ctrl_type           s3_ctrl_ff;
   logic [IDX_W-1:0]          s3_idx_ff, s3_idx_in;
   logic [W_W:0]              s3_wgt_ff, s3_wgt_in;

   assign nzx_in = (2*CELL_W)'(grid_depth) * (2*CELL_W)'(grid_width);

   assign adv         = !s3_valid_ff || rsp_pop;
   assign issue       = adv && job_valid;
   assign last_corner = job_ctrl.fault || (k_ff == 4'd15)
                     || ((k_ff == 4'd7) && !job_ctrl.dipole);
   assign job_pop     = issue && last_corner;

   always_comb begin
      k_in = k_ff;
      if (issue) begin
         k_in = last_corner ? 4'd0 : k_ff + 4'd1;
      end
   end

   always_comb begin
      logic [W_W-1:0] frac_ext;
      for (int a = 0; a < 3; a++) begin
         frac_ext    = {1'b0, job_frac[k_ff[3]][a]};
         sel_w[a]    = k_ff[a] ? frac_ext : {1'b1, {FRAC_BITS{1'b0}}} - frac_ext;
         sel_cell[a] = job_cell[k_ff[3]][a] + CELL_W'(k_ff[a]);
      end
      sel_ctrl.fault = job_ctrl.fault;
      sel_ctrl.code  = job_ctrl.code;
      sel_ctrl.pole  = job_ctrl.fault ? job_ctrl.pole : 1'b0;
      sel_ctrl.neg   = k_ff[3];
      sel_ctrl.last  = last_corner;
   end

   always_comb begin
      logic [3*CELL_W-1:0] py_full;
      logic [ABC_W-1:0]    abc;
      s1_wab_in = AB_W'(s0_w_ff[AXIS_Z]) * AB_W'(s0_w_ff[AXIS_X]);
      py_full   = (3*CELL_W)'(s0_cell_ff[AXIS_Y]) * (3*CELL_W)'(nzx_ff);
      s1_py_in  = py_full[IDX_W-1:0];
      s1_px_in  = (2*CELL_W)'(s0_cell_ff[AXIS_X]) * (2*CELL_W)'(grid_depth);
      abc       = ABC_W'(s1_wab_ff) * ABC_W'(s1_wc_ff);
      s2_wgt_in = abc[3*FRAC_BITS:2*FRAC_BITS];
      s2_idx_in = s1_py_ff + IDX_W'(s1_px_ff) + IDX_W'(s1_cz_ff);
      if (s2_ctrl_ff.fault) begin
         s3_idx_in = '0;
         s3_wgt_in = '0;
      end else begin
         s3_idx_in = s2_idx_ff;
         s3_wgt_in = s2_ctrl_ff.neg ? (W_W+1)'(0) - {1'b0, s2_wgt_ff} : {1'b0, s2_wgt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nzx_ff      <= '0;
         k_ff        <= 4'd0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         nzx_ff <= nzx_in;
         k_ff   <= k_in;
         if (adv) begin
            s0_valid_ff <= issue;
            s1_valid_ff <= s0_valid_ff;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ctrl_ff <= sel_ctrl;
         s0_w_ff    <= sel_w;
         s0_cell_ff <= sel_cell;
         s1_ctrl_ff <= s0_ctrl_ff;
         s1_wab_ff  <= s1_wab_in;
         s1_wc_ff   <= s0_w_ff[AXIS_Y];
         s1_py_ff   <= s1_py_in;
         s1_px_ff   <= s1_px_in;
         s1_cz_ff   <= s0_cell_ff[AXIS_Z];
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_wgt_ff  <= s2_wgt_in;
         s2_idx_ff  <= s2_idx_in;
         s3_ctrl_ff <= s2_ctrl_ff;
         s3_idx_ff  <= s3_idx_in;
         s3_wgt_ff  <= s3_wgt_in;
      end
   end

   assign rsp_empty         = !s3_valid_ff;
   assign rsp_point_index   = s3_idx_ff;
   assign rsp_corner_weight = signed'(s3_wgt_ff);
   assign rsp_fault_code    = s3_ctrl_ff.code;
   assign rsp_fault_pole    = s3_ctrl_ff.pole;
   assign rsp_last_of_run   = s3_ctrl_ff.last;

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("job popped from an empty queue");

   a_fault_first_corner: assert property (@(posedge clock) disable iff (reset)
      (issue && job_ctrl.fault) |-> (k_ff == 4'd0))
      else $error("fault beat issued after corners of the same job");

   a_second_pole_dipole: assert property (@(posedge clock) disable iff (reset)
      (job_valid && k_ff[3]) |-> job_ctrl.dipole)
      else $error("second pole corners for a job without dipole");

   a_stall_holds_seq: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (k_ff == $past(k_ff)))
      else $error("corner sequencer moved during an output stall");

endmodule

[rtl/trilinear_stencil_weights.sv]
// Top level of the trilinear stencil weight generator.
//
// Input beats arrive on the req_ queue port (push/full) and carry one
// device position plus an optional second pole offset. Each beat yields
// 8 corner beats, 16 when the second pole is on, or a single fault beat
// when a pole lies outside the configured bounds. Result beats leave on
// the rsp_ queue port (empty/pop); rsp_last_of_run marks the final beat.
// A result passes the front input register, the job queue and the back
// stages s0 to s3. The corner sequencer issues one result per cycle while
// the receiver does not stall, and beats follow each other without gaps;
// a two-entry job queue lets the front accept the next position while
// the back still emits corners.
// When the receiver stalls, the whole back pipeline holds, the job queue
// fills and full rises. Reset empties all stages and loads the defaults:
// depth 2, width 2, first bounds 0, end bounds 1. Registers are written
// through csr_ one per cycle; the user must write only while idle (unchecked).
module trilinear_stencil_weights #(
   parameter int GRID_BITS = tsw_pkg::GRID_BITS_DEF,
   parameter int FRAC_BITS = tsw_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [tsw_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [GRID_BITS:0]                    csr_wdata,
   input  logic                                  push,
   output logic                                  full,
   input  logic [GRID_BITS+FRAC_BITS-1:0]        req_pos_z,
   input  logic [GRID_BITS+FRAC_BITS-1:0]        req_pos_x,
   input  logic [GRID_BITS+FRAC_BITS-1:0]        req_pos_y,
   input  logic                                  req_dipole_on,
   input  logic signed [GRID_BITS+FRAC_BITS-1:0] req_shift_z,
   input  logic signed [GRID_BITS+FRAC_BITS-1:0] req_shift_x,
   input  logic signed [GRID_BITS+FRAC_BITS-1:0] req_shift_y,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [3*GRID_BITS-1:0]                rsp_point_index,
   output logic signed [FRAC_BITS+1:0]           rsp_corner_weight,
   output logic [1:0]                            rsp_fault_code,
   output logic                                  rsp_fault_pole,
   output logic                                  rsp_last_of_run
);
   import tsw_pkg::*;

   localparam int CELL_W = GRID_BITS + 1;
   localparam int JOB_W  = $bits(job_ctrl_type) + 6 * CELL_W + 6 * FRAC_BITS;

   logic [CELL_W-1:0]             grid_depth;
   logic [CELL_W-1:0]             grid_width;
   logic [2:0][GRID_BITS-1:0]     first_ok;
   logic [2:0][CELL_W-1:0]        end_ok;

   logic                          job_push;
   logic                          job_full;
   job_ctrl_type                  push_ctrl;
   logic [1:0][2:0][CELL_W-1:0]   push_cell;
   logic [1:0][2:0][FRAC_BITS-1:0] push_frac;

   logic                          job_valid;
   logic                          job_pop;
   job_ctrl_type                  head_ctrl;
   logic [1:0][2:0][CELL_W-1:0]   head_cell;
   logic [1:0][2:0][FRAC_BITS-1:0] head_frac;
   logic [JOB_W-1:0]              fifo_wdata;
   logic [JOB_W-1:0]              fifo_rdata;

   tsw_csr #(
      .GRID_BITS (GRID_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .grid_depth (grid_depth),
      .grid_width (grid_width),
      .first_ok   (first_ok),
      .end_ok     (end_ok)
   );

   tsw_front #(
      .GRID_BITS (GRID_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (push),
      .req_full      (full),
      .req_pos_z     (req_pos_z),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_dipole_on (req_dipole_on),
      .req_shift_z   (req_shift_z),
      .req_shift_x   (req_shift_x),
      .req_shift_y   (req_shift_y),
      .first_ok      (first_ok),
      .end_ok        (end_ok),
      .job_push      (job_push),
      .job_full      (job_full),
      .job_ctrl      (push_ctrl),
      .job_cell      (push_cell),
      .job_frac      (push_frac)
   );

   assign fifo_wdata = {push_ctrl, push_cell, push_frac};
   assign {head_ctrl, head_cell, head_frac} = fifo_rdata;

   tsw_job_fifo #(
      .WIDTH (JOB_W)
   ) u_job_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .full  (job_full),
      .wdata (fifo_wdata),
      .pop   (job_pop),
      .valid (job_valid),
      .rdata (fifo_rdata)
   );

   tsw_back #(
      .GRID_BITS (GRID_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job_pop           (job_pop),
      .job_ctrl          (head_ctrl),
      .job_cell          (head_cell),
      .job_frac          (head_frac),
      .grid_depth        (grid_depth),
      .grid_width        (grid_width),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_point_index   (rsp_point_index),
      .rsp_corner_weight (rsp_corner_weight),
      .rsp_fault_code    (rsp_fault_code),
      .rsp_fault_pole    (rsp_fault_pole),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
